[hdl/crt_pkg.sv]
// Package: widths, register indexes, reset values and shared types of the clock ratio tracker.
package crt_pkg;

  localparam int unsigned TS_W          = 64;
  localparam int unsigned CAND_W        = 42;
  localparam int unsigned NOISE_W       = 32;
  localparam int unsigned WEIGHT_W      = 16;
  localparam int unsigned BUCKET_W      = 4;
  localparam int unsigned FRAC_BITS_DEF = 40;
  localparam int unsigned CFG_ADDR_W    = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_TS_MASK    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NOISE_BAND = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPEC_LOW   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPEC_HIGH  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_KEEP_W     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BUCKET_LIM = 3'd5;

  localparam logic [TS_W-1:0]     TS_MASK_RST    = 64'd1099511627775;
  localparam logic [NOISE_W-1:0]  NOISE_BAND_RST = 32'd32985;
  localparam logic [CAND_W-1:0]   SPEC_LOW_RST   = 42'd1099489637543;
  localparam logic [CAND_W-1:0]   SPEC_HIGH_RST  = 42'd1099533618009;
  localparam logic [WEIGHT_W-1:0] KEEP_W_RST     = 16'd6554;
  localparam logic [BUCKET_W-1:0] BUCKET_LIM_RST = 4'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_DIV,
    S_CMP,
    S_MUL,
    S_UPD
  } crt_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/crt_div.sv]
// Bit-serial restoring divider: floor(num * 2^FRAC_BITS / den), saturated to the candidate width.
module crt_div
  import crt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TS_W-1:0]   num_i,
  input  logic [TS_W-1:0]   den_i,
  output div_stat_t         stat_o,
  output logic [CAND_W-1:0] quot_o
);

  localparam int unsigned STEPS = TS_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TS_W-1:0]   num_q;
  logic [TS_W-1:0]   den_q;
  logic [TS_W-1:0]   rem_q;
  logic [CAND_W-1:0] quot_q;
  logic              sat_q;

  logic [TS_W:0]     rem_sh;
  logic [TS_W:0]     rem_sub;
  logic              qbit;

  // the shifted remainder can reach 65 bits; anything at or above 2^64 beats den
  assign rem_sh  = {rem_q, num_q[TS_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign qbit    = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      sat_q  <= 1'b0;
    end else if (busy_q) begin
      num_q  <= {num_q[TS_W-2:0], 1'b0};
      rem_q  <= qbit ? rem_sub[TS_W-1:0] : rem_sh[TS_W-1:0];
      quot_q <= {quot_q[CAND_W-2:0], qbit};
      if (qbit && (cnt_q >= CNT_W'(CAND_W))) begin
        sat_q <= 1'b1;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = sat_q ? {CAND_W{1'b1}} : quot_q;

endmodule

[hdl/clock_ratio_tracker.sv]
// Steps: an accepted word passes the launch, divide, compare, multiply and update steps; the
// one-bit-a-cycle ratio divider does the divide step, which is skipped when the local tick
// count is zero. Throughput: one word at a time, the next accepted the cycle after the result
// is loaded; a stalled output holds the update step.
// Reset: asynchronous, active low; configuration registers return to their reset values, the kept
// correction and the bucket clear, and no result is pending.
module clock_ratio_tracker
  import crt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // ref_new, ref_old, loc_new, loc_old (64 bits each, from bit 0 up)
  input  logic [4*TS_W-1:0]     s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // correction[41:0], candidate[83:42], candidate_valid[84], reliable[85],
  // reference_taken[86], zero[87]
  output logic [87:0]           m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [TS_W-1:0]       cfg_wdata_i
);

  crt_state_e state_q, state_d;

  logic [TS_W-1:0]     ts_mask_q;
  logic [NOISE_W-1:0]  noise_q;
  logic [CAND_W-1:0]   spec_low_q;
  logic [CAND_W-1:0]   spec_high_q;
  logic [WEIGHT_W-1:0] keep_w_q;
  logic [BUCKET_W-1:0] bucket_lim_q;

  logic [CAND_W-1:0]   kept_q, kept_d;
  logic [BUCKET_W-1:0] bucket_q, bucket_d;

  logic [TS_W-1:0]     dref_q;
  logic [TS_W-1:0]     dloc_q;
  logic                cvalid_q;
  logic [CAND_W-1:0]   cand_q;
  logic [CAND_W:0]     diff_q;
  logic                reliable_q;
  logic                in_spec_q;
  logic signed [50:0]  prod_q;

  logic                m_valid_q;
  logic [87:0]         m_data_q;

  logic                in_fire;
  logic                upd_fire;
  logic                div_start;
  div_stat_t           div_stat;
  logic [CAND_W-1:0]   div_quot;
  logic [CAND_W-1:0]   cand_w;
  logic [CAND_W:0]     diff_abs;
  logic [16:0]         w_comp;
  logic signed [50:0]  adj;
  logic [CAND_W-1:0]   kept_filt;
  logic                taken;

  crt_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (dref_q),
    .den_i  (dloc_q),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign upd_fire      = (state_q == S_UPD) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_mask_q    <= TS_MASK_RST;
      noise_q      <= NOISE_BAND_RST;
      spec_low_q   <= SPEC_LOW_RST;
      spec_high_q  <= SPEC_HIGH_RST;
      keep_w_q     <= KEEP_W_RST;
      bucket_lim_q <= BUCKET_LIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_TS_MASK:    ts_mask_q    <= cfg_wdata_i;
        REG_NOISE_BAND: noise_q      <= cfg_wdata_i[NOISE_W-1:0];
        REG_SPEC_LOW:   spec_low_q   <= cfg_wdata_i[CAND_W-1:0];
        REG_SPEC_HIGH:  spec_high_q  <= cfg_wdata_i[CAND_W-1:0];
        REG_KEEP_W:     keep_w_q     <= cfg_wdata_i[WEIGHT_W-1:0];
        REG_BUCKET_LIM: bucket_lim_q <= cfg_wdata_i[BUCKET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_LAUNCH;
      end
      S_LAUNCH: begin
        if (dloc_q == '0) begin
          state_d = S_CMP;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) state_d = S_CMP;
      end
      S_CMP: state_d = S_MUL;
      S_MUL: state_d = S_UPD;
      S_UPD: begin
        if (upd_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath words
  assign cand_w   = cvalid_q ? div_quot : '0;
  assign diff_abs = diff_q[CAND_W] ? (~diff_q + 1'b1) : diff_q;
  assign w_comp   = 17'h10000 - {1'b0, keep_w_q};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dref_q <= (s_axis_tdata[TS_W-1:0] - s_axis_tdata[2*TS_W-1:TS_W]) & ts_mask_q;
      dloc_q <= (s_axis_tdata[3*TS_W-1:2*TS_W] - s_axis_tdata[4*TS_W-1:3*TS_W]) & ts_mask_q;
    end
    if (state_q == S_LAUNCH) begin
      cvalid_q <= (dloc_q != '0);
    end
    if (state_q == S_CMP) begin
      cand_q <= cand_w;
      diff_q <= {1'b0, cand_w} - {1'b0, kept_q};
    end
    if (state_q == S_MUL) begin
      // |diff| < noise band keeps it within 33 signed bits whenever the filter is used
      reliable_q <= cvalid_q && (diff_abs < {{(CAND_W+1-NOISE_W){1'b0}}, noise_q});
      in_spec_q  <= (spec_low_q < cand_q) && (cand_q < spec_high_q);
      prod_q     <= $signed(diff_q[32:0]) * $signed({1'b0, w_comp});
    end
  end

  // kept + round((cand - kept) * (1 - w)), same as the weighted sum with half-up rounding
  assign adj       = (prod_q + 51'sd32768) >>> 16;
  assign kept_filt = kept_q + adj[CAND_W-1:0];

  always_comb begin
    kept_d   = kept_q;
    bucket_d = bucket_q;
    taken    = 1'b0;
    priority if (reliable_q) begin
      kept_d = kept_filt;
      if (bucket_q < bucket_lim_q) bucket_d = bucket_q + 1'b1;
    end else if (bucket_q != '0) begin
      bucket_d = bucket_q - 1'b1;
    end else if (cvalid_q && in_spec_q) begin
      kept_d = cand_q;
      taken  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q    <= '0;
      bucket_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (upd_fire) begin
        kept_q    <= kept_d;
        bucket_q  <= bucket_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      m_data_q <= {1'b0, taken, reliable_q, cvalid_q, cand_q, kept_d};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == S_UPD)
    else $error("result appeared outside the update step");

  a_kept_only_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kept_q != $past(kept_q)) |-> $past(upd_fire))
    else $error("kept correction changed outside the update step");

  a_bucket_fill_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bucket_q > $past(bucket_q)) |-> (bucket_q <= $past(bucket_lim_q)))
    else $error("bucket filled beyond its limit");

  a_flags_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(m_data_q[86] && m_data_q[85]) && !(m_data_q[85] && !m_data_q[84]))
    else $error("reliable and reference taken flags disagree");
`endif

endmodule
